[sv/wpt_pkg.sv]
// Shared constants, command codes and cell interface types for the
// window percentile tracker. No dependencies.
`default_nettype none
package wpt_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int AW           = $clog2(WINDOW_DEPTH);
  localparam int CW           = $clog2(WINDOW_DEPTH + 1);
  localparam int DW           = 32;
  localparam int LW           = 11;
  localparam int PCTW         = 7;
  localparam int SW           = DW + CW;
  localparam int PW           = PCTW + CW + 1;
  localparam int DefaultLimit = (1000 < WINDOW_DEPTH) ? 1000 : WINDOW_DEPTH;
  localparam int RankRound    = 99;
  localparam int Hundred      = 100;
  localparam int RecipMul     = 5243;
  localparam int RecipShift   = 19;
  localparam int RecW         = PW + 13;
  localparam int GroupSize    = 32;
  localparam int NumGroups    = (WINDOW_DEPTH + GroupSize - 1) / GroupSize;
  localparam int InW          = ((DW + PCTW + 7) / 8) * 8;
  localparam int OutW         = ((2 * DW + CW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_CLR  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DW-1:0]     key;
  } cell_cmd_t;

  typedef struct packed {
    logic              le;
    logic              lt;
    logic              valid;
    logic [DW-1:0]     val;
  } cell_out_t;

endpackage
`default_nettype wire

[sv/wpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[sv/wpt_cell.sv]
// One cell of the sorted sample chain: holds a value and a valid bit.
// Depends on wpt_pkg.
`default_nettype none
module wpt_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wpt_pkg::cell_cmd_t cmd_i,
  input  wire wpt_pkg::cell_out_t prev_i,
  input  wire wpt_pkg::cell_out_t next_i,
  output wpt_pkg::cell_out_t      state_o
);
  import wpt_pkg::*;

  logic          valid_q, valid_d;
  logic [DW-1:0] val_q, val_d;
  logic          le, lt;

  assign le = valid_q && (val_q <= cmd_i.key);
  assign lt = valid_q && (val_q < cmd_i.key);

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    case (cmd_i.op)
      OP_INS: begin
        if (!le) begin
          if (prev_i.le) begin
            valid_d = 1'b1;
            val_d   = cmd_i.key;
          end else begin
            valid_d = prev_i.valid;
            val_d   = prev_i.val;
          end
        end
      end
      OP_DEL: begin
        // first cell not below the key holds the dropped value: pull up
        if (!lt) begin
          valid_d = next_i.valid;
          val_d   = next_i.val;
        end
      end
      OP_CLR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign state_o = '{le: le, lt: lt, valid: valid_q, val: val_q};

endmodule
`default_nettype wire

[sv/wpt_chain.sv]
// Row of sorted cells plus a two-stage registered select tree for rank reads.
// Depends on wpt_pkg and wpt_cell.
`default_nettype none
module wpt_chain (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire wpt_pkg::cell_cmd_t     cmd_i,
  input  wire logic                   sel_start_i,
  input  wire logic [wpt_pkg::AW-1:0] sel_idx_i,
  output logic                        sel_done_o,
  output logic [wpt_pkg::DW-1:0]      sel_value_o
);
  import wpt_pkg::*;

  localparam cell_out_t HeadEnd = '{le: 1'b1, lt: 1'b1, valid: 1'b0, val: '0};
  localparam cell_out_t TailEnd = '{le: 1'b0, lt: 1'b0, valid: 1'b0, val: '0};

  cell_out_t st [WINDOW_DEPTH];

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    wpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_i),
      .prev_i ((i == 0) ? HeadEnd : st[(i == 0) ? 0 : i - 1]),
      .next_i ((i == WINDOW_DEPTH - 1) ? TailEnd : st[(i == WINDOW_DEPTH - 1) ? i : i + 1]),
      .state_o(st[i])
    );
  end

  logic [DW-1:0] grp_q [NumGroups];
  logic [DW-1:0] grp_d [NumGroups];
  logic          v1_q, v2_q;
  logic [DW-1:0] out_q, out_d;

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        if ((g * GroupSize + j) < WINDOW_DEPTH) begin
          if (st[g * GroupSize + j].valid && (sel_idx_i == AW'(g * GroupSize + j))) begin
            grp_d[g] = grp_d[g] | st[g * GroupSize + j].val;
          end
        end
      end
    end
  end

  always_comb begin
    out_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      out_d = out_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= sel_start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    out_q <= out_d;
  end

  assign sel_done_o  = v2_q;
  assign sel_value_o = out_q;

endmodule
`default_nettype wire

[sv/wpt_div.sv]
// Bit-serial restoring divider for the window mean, one quotient bit a cycle.
// Depends on wpt_pkg.
`default_nettype none
module wpt_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [wpt_pkg::SW-1:0] dividend_i,
  input  wire logic [wpt_pkg::CW-1:0] divisor_i,
  output logic                        busy_o,
  output logic [wpt_pkg::DW-1:0]      quot_o
);
  import wpt_pkg::*;

  localparam int NW = $clog2(SW + 1);

  logic          busy_q;
  logic [NW-1:0] cnt_q;
  logic [SW-1:0] dvd_q, quo_q;
  logic [CW-1:0] div_q;
  logic [CW:0]   rem_q, rem_sh;
  logic          take;

  assign rem_sh = {rem_q[CW-1:0], dvd_q[SW-1]};
  assign take   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= NW'(SW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != NW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SW-2:0], 1'b0};
      rem_q <= take ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_q <= {quo_q[SW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q[DW-1:0];

endmodule
`default_nettype wire

[sv/window_percentile_tracker.sv]
// Top level of the sliding-window percentile tracker.
// Depends on wpt_pkg, wpt_ram, wpt_chain and wpt_div.
`default_nettype none
// Keeps the last window_limit samples twice: in arrival order in a RAM (to
// know which sample to drop) and in sorted order in a chain of WINDOW_DEPTH
// cells that shift on every insert or drop. A record inserts the sample, and
// when the window is full first drops the oldest, then inserts. A query
// waits for the bit-serial divider that forms the mean, which sets when the
// result shows; the rank read through the select tree finishes before it.
// A query on an empty window skips the divider. One request is worked on at
// a time; a finished result waits in the output register while the next
// request is taken.
module window_percentile_tracker (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [wpt_pkg::LW-1:0]   cfg_data_i,     // window_limit
  input  wire logic                     s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire logic [wpt_pkg::InW-1:0]  s_axis_tdata_i, // sample, percent
  input  wire logic [1:0]               s_axis_tuser_i, // cmd
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  output logic [wpt_pkg::OutW-1:0]      m_axis_tdata_o  // value, mean_value, sample_count
);
  import wpt_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_DEL  = 8'b00000010,
    ST_INS  = 8'b00000100,
    ST_Q1   = 8'b00001000,
    ST_Q2   = 8'b00010000,
    ST_Q3   = 8'b00100000,
    ST_WAIT = 8'b01000000,
    ST_DONE = 8'b10000000
  } state_e;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW + 1)'(a) + (CW + 1)'(b);
    if (s >= (CW + 1)'(WINDOW_DEPTH)) s = s - (CW + 1)'(WINDOW_DEPTH);
    return s[AW-1:0];
  endfunction

  state_e         state_q, state_d;
  logic [LW-1:0]  cfg_q;
  logic [CW-1:0]  lim;
  logic [AW-1:0]  old_q, old_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [SW-1:0]  sum_q, sum_d;
  logic [DW-1:0]  smp_q;
  logic [PCTW-1:0] pct_q;
  logic [CW-1:0]  n_q;
  logic [PW-1:0]  prod_q;
  logic [RecW-1:0] rec_q;
  logic           sel_ok_q;
  logic           mval_q;
  logic [DW-1:0]  mvalue_q, mmean_q;
  logic [CW-1:0]  mcount_q;

  logic           s_acc, full, ram_re, ram_we;
  cmd_e           cmd;
  cell_cmd_t      ccmd;
  logic [DW-1:0]  ram_rdata;
  logic           sel_start, sel_done, div_start, div_busy;
  logic [AW-1:0]  sel_idx;
  logic [DW-1:0]  sel_value, quot;
  logic [PW-1:0]  q0, qf;
  logic [PW+6:0]  chk;
  logic [CW-1:0]  rank;
  logic           load_out;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = cmd_e'(s_axis_tuser_i);

  always_comb begin
    if (cfg_q == '0) begin
      lim = CW'(DefaultLimit);
    end else if (32'(cfg_q) > 32'(WINDOW_DEPTH)) begin
      lim = CW'(WINDOW_DEPTH);
    end else begin
      lim = CW'(cfg_q);
    end
  end

  assign full   = (cnt_q >= lim) && (cnt_q != '0);
  assign ram_re = s_acc && (cmd == CMD_RECORD) && full;
  assign ram_we = (state_q == ST_INS);

  // rank = ceil(pct * n / 100) through a reciprocal that runs at most one high
  assign q0  = PW'(rec_q >> RecipShift);
  assign chk = (PW + 7)'(q0) * (PW + 7)'(Hundred);
  always_comb begin
    qf = (chk > (PW + 7)'(prod_q)) ? q0 - 1'b1 : q0;
    if (qf == '0) qf = PW'(1);
    if (qf > PW'(n_q)) qf = PW'(n_q);
    rank = CW'(qf);
  end
  assign sel_idx   = AW'(rank - 1'b1);
  assign sel_start = (state_q == ST_Q3);
  assign div_start = (state_q == ST_Q3) && (n_q != '0);
  assign load_out  = (state_q == ST_DONE) && (!mval_q || m_axis_tready_i);

  always_comb begin
    state_d  = state_q;
    old_d    = old_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    ccmd.op  = OP_HOLD;
    ccmd.key = smp_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          case (cmd)
            CMD_RECORD: state_d = full ? ST_DEL : ST_INS;
            CMD_QUERY:  state_d = ST_Q1;
            CMD_CLEAR: begin
              ccmd.op = OP_CLR;
              old_d   = '0;
              cnt_d   = '0;
              sum_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DEL: begin
        ccmd.op  = OP_DEL;
        ccmd.key = ram_rdata;
        sum_d    = sum_q - SW'(ram_rdata);
        old_d    = wrap_add(old_q, CW'(1));
        cnt_d    = cnt_q - 1'b1;
        state_d  = ST_INS;
      end
      ST_INS: begin
        ccmd.op = OP_INS;
        sum_d   = sum_q + SW'(smp_q);
        cnt_d   = cnt_q + 1'b1;
        state_d = ST_IDLE;
      end
      ST_Q1:   state_d = ST_Q2;
      ST_Q2:   state_d = ST_Q3;
      ST_Q3:   state_d = ST_WAIT;
      ST_WAIT: if (sel_ok_q && !div_busy) state_d = ST_DONE;
      ST_DONE: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_q    <= LW'(1000);
      old_q    <= '0;
      cnt_q    <= '0;
      sum_q    <= '0;
      sel_ok_q <= 1'b0;
      mval_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      old_q   <= old_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      if (sel_start) begin
        sel_ok_q <= 1'b0;
      end else if (sel_done) begin
        sel_ok_q <= 1'b1;
      end
      if (load_out) begin
        mval_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        mval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      smp_q <= s_axis_tdata_i[DW-1:0];
      pct_q <= s_axis_tdata_i[DW+PCTW-1:DW];
      n_q   <= cnt_q;
    end
    prod_q <= PW'(pct_q) * PW'(n_q) + PW'(RankRound);
    rec_q  <= RecW'(prod_q) * RecW'(RecipMul);
    if (load_out) begin
      mvalue_q <= (n_q == '0) ? '0 : sel_value;
      mmean_q  <= (n_q == '0) ? '0 : quot;
      mcount_q <= n_q;
    end
  end

  wpt_ram #(.WIDTH(DW), .DEPTH(WINDOW_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wrap_add(old_q, cnt_q)),
    .wdata_i(smp_q),
    .re_i   (ram_re),
    .raddr_i(old_q),
    .rdata_o(ram_rdata)
  );

  wpt_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ccmd),
    .sel_start_i(sel_start),
    .sel_idx_i  (sel_idx),
    .sel_done_o (sel_done),
    .sel_value_o(sel_value)
  );

  wpt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (n_q),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  assign m_axis_tvalid_o = mval_q;
  assign m_axis_tdata_o  = {(OutW - 2 * DW - CW)'(0), mcount_q, mmean_q, mvalue_q};

endmodule
`default_nettype wire

[sv/wpt_checker.sv]
// Port-level checks for the window percentile tracker, bound to the top.
// Depends on wpt_pkg.
`default_nettype none
module wpt_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tvalid_i,
  input wire logic                    s_axis_tready_o,
  input wire logic [1:0]              s_axis_tuser_i,
  input wire logic                    m_axis_tvalid_o,
  input wire logic                    m_axis_tready_i,
  input wire logic [wpt_pkg::OutW-1:0] m_axis_tdata_o
);
  import wpt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2*DW+CW-1:2*DW] <= CW'(WINDOW_DEPTH))
    else $error("sample count above depth");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2*DW+CW-1:2*DW] == '0)
      |-> m_axis_tdata_o[2*DW-1:0] == '0)
    else $error("empty window gave nonzero value or mean");

  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == CMD_QUERY)
      |=> !$rose(m_axis_tvalid_o))
    else $error("query result appeared too early");

endmodule

bind window_percentile_tracker wpt_checker u_wpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
`default_nettype wire
